### rtl/psqe_pkg.sv
// Package for the path stroke quad expander.
// Holds shared widths, opcodes, the controller state type and the command/status structs.
package psqe_pkg;

  localparam int CoordW  = 16;
  localparam int OutW    = 18;
  localparam int WidthW  = 12;
  localparam logic [WidthW-1:0] WidthReset = 12'd16;

  typedef enum logic [1:0] {
    OP_MOVE   = 2'd0,
    OP_LINE   = 2'd1,
    OP_CLOSE  = 2'd2,
    OP_FINISH = 2'd3
  } opcode_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SQRT,
    ST_DIVX,
    ST_DIVY,
    ST_OFFS,
    ST_EMIT,
    ST_UPDATE
  } state_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic load;       // capture input item
    logic setup;      // latch segment endpoints (implicit close or real segment)
    logic use_close;  // segment goes pen -> subpath start
    logic sqrt_step;
    logic divx_init;
    logic divx_step;
    logic divy_init;
    logic divy_step;
    logic offs;
    logic emit_adv;
    logic upd_close;  // state update of a close
    logic upd_cmd;    // state update of the command itself
  } psqe_cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    opcode_t op;
    logic    open_sub;   // !after_move && !after_close
    logic    zero_len;
    logic    sqrt_done;
    logic    div_done;
    logic    emit_last;
  } psqe_stat_t;

endpackage

### rtl/psqe_stream_if.sv
// Valid/ready channel interface used by the stroke expander.
// Depends on no package; widths are given by parameter.
interface psqe_stream_if #(
  parameter int W = 1
) ;
  logic         valid;
  logic         ready;
  logic [W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/psqe_ctrl.sv
// Controller state machine of the stroke expander.
// Depends on psqe_pkg for the state, command and status types.
module psqe_ctrl import psqe_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_fire,
  input  logic       out_fire,
  input  psqe_stat_t stat,
  output psqe_cmd_t  cmd,
  output logic       busy,
  output logic       out_valid
);

  state_t state_r, state_nxt;
  logic   closing_r, closing_nxt;  // the current segment is an implicit close

  // Next state.
  always_comb begin
    state_nxt   = state_r;
    closing_nxt = closing_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) state_nxt = ST_DECODE;
      end
      ST_DECODE: begin
        if (stat.op == OP_CLOSE ||
            ((stat.op == OP_MOVE || stat.op == OP_FINISH) && stat.open_sub)) begin
          closing_nxt = 1'b1;
          state_nxt   = ST_SQRT;
        end else if (stat.op == OP_LINE) begin
          closing_nxt = 1'b0;
          state_nxt   = ST_SQRT;
        end else begin
          closing_nxt = 1'b0;
          state_nxt   = ST_UPDATE;
        end
      end
      ST_SQRT: begin
        if (stat.zero_len) state_nxt = ST_UPDATE;
        else if (stat.sqrt_done) state_nxt = ST_DIVX;
      end
      ST_DIVX: begin
        if (stat.div_done) state_nxt = ST_DIVY;
      end
      ST_DIVY: begin
        if (stat.div_done) state_nxt = ST_OFFS;
      end
      ST_OFFS:  state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (out_fire && stat.emit_last) state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        // After an implicit close, a move still needs its own update.
        if (closing_r && stat.op != OP_CLOSE && stat.op != OP_FINISH) begin
          closing_nxt = 1'b0;
          state_nxt   = ST_UPDATE;
        end else begin
          closing_nxt = 1'b0;
          state_nxt   = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd       = '0;
    busy      = (state_r != ST_IDLE);
    out_valid = 1'b0;
    cmd.use_close = closing_r;
    unique case (state_r)
      ST_IDLE:   cmd.load = in_fire;
      ST_DECODE: begin
        cmd.setup     = 1'b1;
        cmd.use_close = (stat.op != OP_LINE);
      end
      ST_SQRT:   cmd.sqrt_step = 1'b1;
      ST_DIVX: begin
        cmd.divx_step = 1'b1;
        cmd.divy_init = stat.div_done;
      end
      ST_DIVY:   cmd.divy_step = 1'b1;
      ST_OFFS:   cmd.offs = 1'b1;
      ST_EMIT: begin
        out_valid    = 1'b1;
        cmd.emit_adv = out_fire;
      end
      ST_UPDATE: begin
        cmd.upd_close = closing_r;
        cmd.upd_cmd   = !closing_r || stat.op == OP_CLOSE || stat.op == OP_FINISH ? !closing_r
                                                                                 : 1'b0;
      end
      default: ;
    endcase
    cmd.divx_init = (state_r == ST_SQRT) && stat.sqrt_done && !stat.zero_len;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      closing_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      closing_r <= closing_nxt;
    end
  end

`ifndef SYNTHESIS
  // Results only appear while emitting.
  a_emit_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> state_r == ST_EMIT) else $error("output valid outside emit");
  // An accepted item always leaves idle.
  a_leave_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r == ST_DECODE) else $error("accept did not start decode");
  // The last vertex handshake ends the emission.
  a_emit_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && out_fire && stat.emit_last) |=> state_r == ST_UPDATE)
    else $error("emit did not end");
`endif

endmodule

### rtl/psqe_dp.sv
// Datapath of the stroke expander: path state, bit-serial square root,
// restoring divider, offset multiply and vertex generation. Depends on psqe_pkg.
module psqe_dp import psqe_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  psqe_cmd_t                cmd,
  input  logic [1:0]               in_opcode,
  input  logic signed [CoordW-1:0] in_point_x,
  input  logic signed [CoordW-1:0] in_point_y,
  input  logic                     cfg_we,
  input  logic [WidthW-1:0]        cfg_wdata,
  output psqe_stat_t               stat,
  output logic signed [OutW-1:0]   vertex_x,
  output logic signed [OutW-1:0]   vertex_y,
  output logic                     last_vertex
);

  localparam int DW = CoordW + 1;   // difference width
  localparam int RW = 2 * DW + 14;  // square root result bits
  localparam int QW = 16;           // quotient width

  logic [WidthW-1:0]        hw_r;
  opcode_t                  op_r;
  logic signed [CoordW-1:0] px_r, py_r;
  logic signed [CoordW-1:0] pen_x_r, pen_y_r, sub_x_r, sub_y_r;
  logic                     after_move_r, after_close_r;
  logic signed [CoordW-1:0] sx_r, sy_r, ex_r, ey_r;
  logic signed [DW-1:0]     dx_r, dy_r;
  logic                     zero_r;

  // Square root: radicand is L << 28, 2*RW bits, one result bit a cycle.
  logic [2*RW-1:0] rad_r;
  logic [RW-1:0]   root_r;
  logic [RW+1:0]   rem_r;
  logic [6:0]      sq_cnt_r;
  logic [RW+1:0]   trial;
  logic [RW+1:0]   rem_sh;

  // Divider: (mag << 28 + s/2) / s, one quotient bit a cycle.
  logic [DW+28:0]  dividend_r;
  logic [RW:0]     drem_r;
  logic [QW:0]     quo_r;
  logic [5:0]      dv_cnt_r;
  logic [RW+1:0]   drem_sh;
  logic            nx_neg_r, ny_neg_r;
  logic [QW-1:0]   nx_r, ny_r;

  logic signed [OutW-1:0] ox_r, oy_r;
  logic [2:0]             vidx_r;

  logic [DW-1:0] mag_x, mag_y;
  logic [DW+28:0] num_x, num_y;
  logic [14:0]    qclamp;
  logic [27:0]    prod;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) hw_r <= WidthReset;
    else if (cfg_we) hw_r <= cfg_wdata;
  end

  // Input capture.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= opcode_t'(in_opcode);
      px_r <= in_point_x;
      py_r <= in_point_y;
    end
  end

  // Path state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pen_x_r <= '0; pen_y_r <= '0; sub_x_r <= '0; sub_y_r <= '0;
      after_move_r <= 1'b1; after_close_r <= 1'b0;
    end else if (cmd.upd_close) begin
      pen_x_r <= sub_x_r; pen_y_r <= sub_y_r;
      after_move_r <= 1'b0; after_close_r <= 1'b1;
    end else if (cmd.upd_cmd) begin
      unique case (op_r)
        OP_MOVE: begin
          pen_x_r <= px_r; pen_y_r <= py_r; sub_x_r <= px_r; sub_y_r <= py_r;
          after_move_r <= 1'b1; after_close_r <= 1'b0;
        end
        OP_LINE: begin
          pen_x_r <= px_r; pen_y_r <= py_r;
          after_move_r <= 1'b0; after_close_r <= 1'b0;
        end
        OP_CLOSE: begin
          pen_x_r <= sub_x_r; pen_y_r <= sub_y_r;
          after_move_r <= 1'b0; after_close_r <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Segment setup.
  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      sx_r <= pen_x_r; sy_r <= pen_y_r;
      if (cmd.use_close) begin
        ex_r <= sub_x_r; ey_r <= sub_y_r;
        dx_r <= DW'(sub_x_r) - DW'(pen_x_r);
        dy_r <= DW'(sub_y_r) - DW'(pen_y_r);
        zero_r <= (sub_x_r == pen_x_r) && (sub_y_r == pen_y_r);
      end else begin
        ex_r <= px_r; ey_r <= py_r;
        dx_r <= DW'(px_r) - DW'(pen_x_r);
        dy_r <= DW'(py_r) - DW'(pen_y_r);
        zero_r <= (px_r == pen_x_r) && (py_r == pen_y_r);
      end
    end
  end

  assign mag_x = dx_r[DW-1] ? DW'(-dx_r) : DW'(dx_r);
  assign mag_y = dy_r[DW-1] ? DW'(-dy_r) : DW'(dy_r);

  // Square root iterations; squares are formed in the setup-following cycle.
  assign rem_sh = {rem_r[RW-1:0], rad_r[2*RW-1 -: 2]};
  assign trial  = {root_r, 2'b01};
  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      sq_cnt_r <= '0;
    end else if (cmd.sqrt_step) begin
      if (sq_cnt_r == '0) begin
        rad_r  <= (2*RW)'((mag_x * mag_x + mag_y * mag_y)) << 28;
        root_r <= '0;
        rem_r  <= '0;
        sq_cnt_r <= 7'd1;
      end else if (sq_cnt_r <= 7'(RW)) begin
        rad_r <= rad_r << 2;
        if (rem_sh >= trial) begin
          rem_r  <= rem_sh - trial;
          root_r <= {root_r[RW-2:0], 1'b1};
        end else begin
          rem_r  <= rem_sh;
          root_r <= {root_r[RW-2:0], 1'b0};
        end
        sq_cnt_r <= sq_cnt_r + 7'd1;
      end
    end
  end

  // Divider: shared for both normal components.
  assign num_x = ((DW+29)'(mag_y) << 28) + (DW+29)'(root_r >> 1);
  assign num_y = ((DW+29)'(mag_x) << 28) + (DW+29)'(root_r >> 1);
  assign drem_sh = {drem_r, dividend_r[DW+28]};
  always_ff @(posedge clk) begin
    if (cmd.divx_init || cmd.divy_init) begin
      dividend_r <= cmd.divx_init ? num_x : num_y;
      drem_r <= '0;
      quo_r  <= '0;
      dv_cnt_r <= '0;
      if (cmd.divx_init) nx_neg_r <= !dy_r[DW-1] && dy_r != '0;  // -dy
      else ny_neg_r <= dx_r[DW-1];
    end else if ((cmd.divx_step || cmd.divy_step) && dv_cnt_r != 6'(DW+29)) begin
      dividend_r <= dividend_r << 1;
      if (drem_sh >= (RW+2)'(root_r)) begin
        drem_r <= (RW+1)'(drem_sh - (RW+2)'(root_r));
        quo_r  <= (quo_r[QW] || (|quo_r[QW-1:14] && quo_r[QW-1])) ? quo_r : {quo_r[QW-1:0], 1'b1};
      end else begin
        drem_r <= (RW+1)'(drem_sh);
        quo_r  <= (quo_r[QW]) ? quo_r : {quo_r[QW-1:0], 1'b0};
      end
      dv_cnt_r <= dv_cnt_r + 6'd1;
    end
    if (cmd.divx_step && dv_cnt_r == 6'(DW+29)) nx_r <= {1'b0, qclamp};
    if (cmd.divy_step && dv_cnt_r == 6'(DW+29)) ny_r <= {1'b0, qclamp};
  end
  // Quotient never exceeds about 2^14 plus rounding; clamp to 16384.
  assign qclamp = (quo_r > (QW+1)'(16384)) ? 15'd16384 : quo_r[14:0];

  // Offset multiply: both components are formed and registered together.
  logic [27:0] prod_y;
  assign prod   = 28'(nx_r) * 28'(hw_r);
  assign prod_y = 28'(ny_r) * 28'(hw_r);
  always_ff @(posedge clk) begin
    if (cmd.offs) begin
      ox_r <= nx_neg_r ? -OutW'((prod + 28'd8192) >> 14) : OutW'((prod + 28'd8192) >> 14);
      oy_r <= ny_neg_r ? -OutW'((prod_y + 28'd8192) >> 14) : OutW'((prod_y + 28'd8192) >> 14);
      vidx_r <= '0;
    end else if (cmd.emit_adv) begin
      vidx_r <= vidx_r + 3'd1;
    end
  end

  // Vertex selection and saturation.
  logic signed [OutW:0] bx, by, vx, vy;
  logic                 use_end, plus;
  always_comb begin
    use_end = (vidx_r == 3'd2) || (vidx_r == 3'd3) || (vidx_r == 3'd4);
    plus    = (vidx_r == 3'd0) || (vidx_r == 3'd4) || (vidx_r == 3'd5);
    bx = use_end ? (OutW+1)'(ex_r) : (OutW+1)'(sx_r);
    by = use_end ? (OutW+1)'(ey_r) : (OutW+1)'(sy_r);
    vx = plus ? bx + (OutW+1)'(ox_r) : bx - (OutW+1)'(ox_r);
    vy = plus ? by + (OutW+1)'(oy_r) : by - (OutW+1)'(oy_r);
    if (vx[OutW] != vx[OutW-1]) vertex_x = vx[OutW] ? {1'b1, {(OutW-1){1'b0}}}
                                                    : {1'b0, {(OutW-1){1'b1}}};
    else vertex_x = vx[OutW-1:0];
    if (vy[OutW] != vy[OutW-1]) vertex_y = vy[OutW] ? {1'b1, {(OutW-1){1'b0}}}
                                                    : {1'b0, {(OutW-1){1'b1}}};
    else vertex_y = vy[OutW-1:0];
  end
  assign last_vertex = (vidx_r == 3'd5);

  always_comb begin
    stat.op        = op_r;
    stat.open_sub  = !after_move_r && !after_close_r;
    stat.zero_len  = zero_r;
    stat.sqrt_done = (sq_cnt_r == 7'(RW+1));
    stat.div_done  = (dv_cnt_r == 6'(DW+29));
    stat.emit_last = (vidx_r == 3'd5);
  end

`ifndef SYNTHESIS
  // Vertex index stays within one segment.
  a_vidx: assert property (@(posedge clk) disable iff (!rst_n)
    vidx_r <= 3'd5 || !cmd.emit_adv) else $error("vertex index overrun");
  // Flags never both set.
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    !(after_move_r && after_close_r)) else $error("flags both set");
  // A move update starts a subpath at the pen.
  a_move: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.upd_cmd && op_r == OP_MOVE) |=> (sub_x_r == pen_x_r && sub_y_r == pen_y_r))
    else $error("subpath start mismatch");
`endif

endmodule

### rtl/path_stroke_quad_expander_top.sv
// Top level of the path stroke quad expander.
// Depends on psqe_pkg, psqe_stream_if, psqe_ctrl and psqe_dp.
// One path command at a time. Each command is decoded and then updates the path
// state; a segment of nonzero length adds the bit-serial square root (48 steps),
// two restoring divisions (46 steps each) and six vertex transactions, which stall
// with the output. A move or finish on an open subpath emits the closing segment
// first, and a move then takes a second update of its own.
module path_stroke_quad_expander_top import psqe_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  psqe_stream_if.sink       in_ch,
  psqe_stream_if.source     out_ch,
  input  logic              cfg_we,
  input  logic [WidthW-1:0] cfg_wdata
);

  psqe_cmd_t  cmd;
  psqe_stat_t stat;
  logic       busy, out_valid, in_fire, out_fire;
  logic signed [OutW-1:0] vx, vy;
  logic       lv;

  // Input data: {opcode, point_x, point_y}; output: {vertex_x, vertex_y, last_vertex}.
  assign in_ch.ready  = !busy;
  assign in_fire      = in_ch.valid && !busy;
  assign out_ch.valid = out_valid;
  assign out_fire     = out_valid && out_ch.ready;
  assign out_ch.data  = {vx, vy, lv};

  psqe_ctrl u_ctrl (
    .clk, .rst_n, .in_fire, .out_fire, .stat, .cmd, .busy, .out_valid
  );

  psqe_dp u_dp (
    .clk, .rst_n, .cmd,
    .in_opcode (in_ch.data[33:32]),
    .in_point_x(in_ch.data[31:16]),
    .in_point_y(in_ch.data[15:0]),
    .cfg_we, .cfg_wdata, .stat,
    .vertex_x(vx), .vertex_y(vy), .last_vertex(lv)
  );

endmodule
